// File: rtl/core/rbc_pkg.sv
// Shared types, codes and constants of the retry backoff controller.
package rbc_pkg;

    localparam int CountW   = 8;
    localparam int DelayW   = 31;
    localparam int StatusW  = 10;
    localparam int DecW     = 3;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 31;
    localparam int ShiftW   = 5;

    // Decision codes
    localparam logic [DecW-1:0] DEC_RETRY      = 3'd0;
    localparam logic [DecW-1:0] DEC_COMPLETED  = 3'd1;
    localparam logic [DecW-1:0] DEC_ABORTED    = 3'd2;
    localparam logic [DecW-1:0] DEC_NO_REQUEST = 3'd3;
    localparam logic [DecW-1:0] DEC_TIMED_OUT  = 3'd4;
    localparam logic [DecW-1:0] DEC_EXHAUSTED  = 3'd5;
    localparam logic [DecW-1:0] DEC_OVER_CAP   = 3'd6;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_BASE_DELAY    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_RA_SEC    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CountW-1:0] RST_MAX_RETRIES = 8'd3;
    localparam logic [DelayW-1:0] RST_BASE_DELAY  = 31'd1000;
    localparam logic [DelayW-1:0] RST_MAX_RA_SEC  = 31'd60;

    // Status codes and limits
    localparam logic [StatusW-1:0] STATUS_TOO_MANY = 10'd429;
    localparam logic [StatusW-1:0] STATUS_SRV_LO   = 10'd500;
    localparam logic [StatusW-1:0] STATUS_SRV_HI   = 10'd599;
    localparam logic [ShiftW-1:0]  SHIFT_CAP       = 5'd20;
    localparam logic [9:0]         MS_PER_SEC      = 10'd1000;
    localparam logic [DelayW-1:0]  DELAY_SAT       = {DelayW{1'b1}};

    typedef struct packed {
        logic               aborted;
        logic               reply_present;
        logic               finished;
        logic [StatusW-1:0] http_status;
        logic               has_retry_after;
        logic               retry_after_ok;
        logic [DelayW-1:0]  retry_after_sec;
    } in_t;

    typedef struct packed {
        logic [DecW-1:0]   decision;
        logic [DelayW-1:0] delay_ms;
        logic [CountW-1:0] attempt_index;
    } out_t;

    typedef struct packed {
        logic [CountW-1:0] max_retries;
        logic [DelayW-1:0] base_delay_ms;
        logic [DelayW-1:0] max_retry_after_sec;
    } cfg_t;

endpackage

// File: rtl/core/rbc_cfg_regs.sv
// Configuration register file of the retry backoff controller.
module rbc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rbc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rbc_pkg::CfgDataW-1:0] cfg_data,
    output rbc_pkg::cfg_t                cfg
);
    import rbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_RETRIES: cfg_next.max_retries         = cfg_data[CountW-1:0];
                REG_BASE_DELAY:  cfg_next.base_delay_ms       = cfg_data[DelayW-1:0];
                REG_MAX_RA_SEC:  cfg_next.max_retry_after_sec = cfg_data[DelayW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries         <= RST_MAX_RETRIES;
            cfg_reg.base_delay_ms       <= RST_BASE_DELAY;
            cfg_reg.max_retry_after_sec <= RST_MAX_RA_SEC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/rbc_decide.sv
// Retry decision and backoff delay logic for one attempt outcome.
module rbc_decide (
    input  rbc_pkg::in_t                req,
    input  logic [rbc_pkg::CountW-1:0]  attempt,
    input  rbc_pkg::cfg_t               cfg,
    output rbc_pkg::out_t               res,
    output logic [rbc_pkg::CountW-1:0]  attempt_next
);
    import rbc_pkg::*;

    localparam int WideW = DelayW + 20;
    localparam int MsW   = DelayW + 10;

    logic              retryable;
    logic              exhausted;
    logic [ShiftW-1:0] shift;
    logic [WideW-1:0]  backoff_wide;
    logic [DelayW-1:0] backoff;
    logic              ra_use;
    logic              over_cap;
    logic [MsW-1:0]    ra_ms_wide;
    logic [DelayW-1:0] ra_ms;
    logic [DelayW-1:0] delay;
    logic [DecW-1:0]   decision;

    always_comb
    begin
        retryable = req.http_status inside {STATUS_TOO_MANY, [STATUS_SRV_LO:STATUS_SRV_HI]};
        exhausted = (attempt >= cfg.max_retries);

        // Exponential backoff, capped shift, saturate at the field maximum
        shift        = (attempt < CountW'(SHIFT_CAP)) ? attempt[ShiftW-1:0] : SHIFT_CAP;
        backoff_wide = {{(WideW-DelayW){1'b0}}, cfg.base_delay_ms} << shift;
        backoff      = (|backoff_wide[WideW-1:DelayW]) ? DELAY_SAT
                                                       : backoff_wide[DelayW-1:0];

        // Retry-After only counts when present, parsed and non-zero
        ra_use     = req.has_retry_after && req.retry_after_ok &&
                     (req.retry_after_sec != '0);
        over_cap   = ra_use && (req.retry_after_sec > cfg.max_retry_after_sec);
        ra_ms_wide = {{(MsW-DelayW){1'b0}}, req.retry_after_sec} * MsW'(MS_PER_SEC);
        ra_ms      = (|ra_ms_wide[MsW-1:DelayW]) ? DELAY_SAT : ra_ms_wide[DelayW-1:0];
        delay      = (ra_use && (ra_ms > backoff)) ? ra_ms : backoff;

        if (req.aborted)
            decision = DEC_ABORTED;
        else if (!req.reply_present)
            decision = DEC_NO_REQUEST;
        else if (!req.finished)
            decision = DEC_TIMED_OUT;
        else if (!retryable)
            decision = DEC_COMPLETED;
        else if (exhausted)
            decision = DEC_EXHAUSTED;
        else if (over_cap)
            decision = DEC_OVER_CAP;
        else
            decision = DEC_RETRY;

        res.decision      = decision;
        res.delay_ms      = (decision == DEC_RETRY) ? delay : '0;
        res.attempt_index = attempt;

        // Advance on retry, clear on any final decision
        attempt_next = (decision == DEC_RETRY) ? attempt + CountW'(1) : '0;
    end

endmodule

// File: rtl/core/retry_backoff_controller.sv
// Top level of the retry backoff controller.
//
// Each request carries the outcome of one attempt; the block answers with
// one result per request, in order: the decision (retry or one of the final
// outcomes), the backoff delay in milliseconds for a retry, and the index of
// the attempt the outcome belongs to. Throughput is one request per clock
// while out_ready stays high. Each accepted request is held in an
// input register, the decision logic (status check, capped shift of the base
// delay and the Retry-After times 1000 product) runs between that register
// and the result register. The attempt counter is updated as a request moves
// from the input register to the result register, so the next request in
// line already sees the new count. in_ready depends on out_ready through the
// two registers: both stages advance while the consumer takes results.
// Configuration writes are taken on every cycle and should be made only while
// no request is in flight.
module retry_backoff_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rbc_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rbc_pkg::out_t                out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rbc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rbc_pkg::CfgDataW-1:0] cfg_data
);
    import rbc_pkg::*;

    cfg_t              cfg;

    // Input stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    in_t               s1_data_reg;

    // Result stage
    logic              s2_valid_reg;
    logic              s2_valid_next;
    out_t              s2_data_reg;

    // Attempt counter
    logic [CountW-1:0] attempt_count_reg;
    logic [CountW-1:0] attempt_count_next;

    out_t              dec_res;
    logic [CountW-1:0] dec_attempt_next;

    logic              in_fire;
    logic              s1_fire;
    logic              s2_free;

    rbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbc_decide u_decide (
        .req          (s1_data_reg),
        .attempt      (attempt_count_reg),
        .cfg          (cfg),
        .res          (dec_res),
        .attempt_next (dec_attempt_next)
    );

    // Result register frees when empty or when its result is taken
    assign s2_free  = !s2_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_fire  = in_valid && in_ready;

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    always_comb
    begin
        s1_valid_next      = in_fire || (s1_valid_reg && !s1_fire);
        s2_valid_next      = s1_fire || (s2_valid_reg && !out_ready);
        attempt_count_next = s1_fire ? dec_attempt_next : attempt_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            attempt_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
            attempt_count_reg <= attempt_count_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_data_reg <= in_data;
        if (s1_fire)
            s2_data_reg <= dec_res;
    end

    // Any final decision clears the attempt counter
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (dec_res.decision != DEC_RETRY) |=> attempt_count_reg == '0)
        else $error("attempt counter not cleared after final decision");

    // A retry advances the attempt counter by one
    a_retry_advances: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (dec_res.decision == DEC_RETRY)
        |=> attempt_count_reg == $past(attempt_count_reg) + CountW'(1))
        else $error("attempt counter did not advance on retry");

    // Only a retry carries a delay
    a_delay_only_retry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.decision != DEC_RETRY) |-> out_data.delay_ms == '0)
        else $error("non-zero delay on a final decision");

    // The result index is the count that the request saw
    a_index_matches: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_data.attempt_index == $past(attempt_count_reg))
        else $error("attempt index does not match counter");

endmodule
